// ===== design/lphs_pkg.sv =====
// Shared types, constants and helper functions for the linear-probe hash set.
// Depends on nothing; used by the top level, the datapath and the controller.
`timescale 1ns / 1ps
package lphs_pkg;

	localparam int TableSlots = 1021;
	localparam int KeyWidth   = 32;
	localparam int CfgWidth   = 10;
	localparam logic [CfgWidth-1:0] MaxItemsReset = 10'd786;
	localparam logic [9:0] ProbeCap = 10'd1023;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_LOOKUP = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_OVERFLOW  = 3'd2,
		ST_UNDERFLOW = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_FULL  = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] key;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [31:0] removed_key;
		logic [9:0]  item_count;
		logic [9:0]  max_probes;
		logic [31:0] total_probes;
		logic [31:0] insert_count;
	} rsp_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // capture request, start hashing
		logic hash_step;  // one hashing step
		logic rd;         // read the current slot; never set, memories read always
		logic advance;    // move to next slot
		logic restart;    // return to home slot for insert
		logic do_insert;  // write key into current slot
		logic do_remove;  // tombstone current slot
		logic probe_inc;  // count one insert probe step
		logic finish;     // build response
		logic [2:0] status;
		logic found;
	} cmd_t;

	// Status back to controller
	typedef struct packed {
		logic busy;
		logic hash_done;
		action_t action;
		logic cnt_zero;
		logic at_limit;
		slot_t slot;
		logic key_match;
		logic pass_done;
	} sts_t;

endpackage

// ===== design/linear_probe_hash_set.sv =====
// Top level of the linear-probe hash set: controller, datapath, limit register.
// Depends on lphs_pkg, lphs_ctrl, lphs_datapath.
//
// Channel | Direction | Handshake            | Payload
// req     | in        | req_valid/req_ready  | lphs_pkg::req_t (action, key)
// rsp     | out       | rsp_valid/rsp_ready  | lphs_pkg::rsp_t
// cfg     | in        | cfg_we               | cfg_wdata (max_items)
//
// An item takes the accept cycle, home-slot hashing (reciprocal multiply,
// back-multiply, subtract, reduce) and a read and a check per slot visited;
// insert walks the chain twice (search, then fill). An early reply (limit,
// empty set, unused action) goes from hashing straight to the reply.
// After reset the status memory is swept to empty before the first request
// is taken. One request is in flight; a new request is taken in the cycle
// the waiting reply is taken, and a stalled reply holds the input.
`timescale 1ns / 1ps
module linear_probe_hash_set #(
	parameter int TABLE_SLOTS = lphs_pkg::TableSlots,
	parameter int KEY_WIDTH   = lphs_pkg::KeyWidth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lphs_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lphs_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [9:0]     cfg_wdata
);
	logic [9:0]     max_items_q;
	lphs_pkg::cmd_t cmd;
	lphs_pkg::sts_t sts;
	logic           rsp_valid_c;

	// Hold the set limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_items_q <= lphs_pkg::MaxItemsReset;
		end else if (cfg_we) begin
			max_items_q <= cfg_wdata;
		end
	end

	lphs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_ready(req_ready),
		.out_valid(rsp_valid_c), .out_ready(rsp_ready),
		.sts(sts), .cmd(cmd)
	);

	lphs_datapath #(.TableSlots(TABLE_SLOTS), .KeyWidth(KEY_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .max_items(max_items_q),
		.cmd(cmd), .sts(sts), .rsp(rsp)
	);

	assign rsp_valid = rsp_valid_c;
endmodule

// ===== design/lphs_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module lphs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// Read one entry a cycle, and write it as well when we is set
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== design/lphs_datapath.sv =====
// Datapath: slot memories, probe address, statistics and response register.
// Depends on lphs_pkg and lphs_ram.
`timescale 1ns / 1ps
module lphs_datapath #(
	parameter int TableSlots = lphs_pkg::TableSlots,
	parameter int KeyWidth   = lphs_pkg::KeyWidth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lphs_pkg::req_t     req,
	input  logic [9:0]         max_items,
	input  lphs_pkg::cmd_t     cmd,
	output lphs_pkg::sts_t     sts,
	output lphs_pkg::rsp_t     rsp
);
	localparam int AW = $clog2(TableSlots);
	localparam int CW = $clog2(TableSlots + 1);
	localparam int RW = AW + 1;
	localparam logic [AW-1:0] LastSlot = AW'(TableSlots - 1);
	localparam logic [31:0] Recip  = 32'((64'd1 << 32) / 64'(TableSlots));
	localparam logic [31:0] SlotsW = 32'(TableSlots);

	logic [1:0]          action_q;
	logic [KeyWidth-1:0] key_q;
	logic [63:0]         prod_q;
	logic [31:0]         qp_q;
	logic [RW-1:0]       diff_q;
	logic [1:0]          hcnt_q;
	logic                hash_done_q;
	logic [AW-1:0]       home_q, idx_q;
	logic [CW-1:0]       steps_q;
	logic [9:0]          count_q, longest_q;
	logic [31:0]         psum_q, ins_q;
	logic                clr_busy_q;
	logic [AW-1:0]       clr_idx_q;

	logic [1:0]          st_rd;
	logic [KeyWidth-1:0] key_rd;
	logic                st_we, key_we;
	logic [AW-1:0]       ram_addr;
	logic [1:0]          st_wd;
	logic [9:0]          steps_cap;
	logic [31:0]         key32;
	logic [AW-1:0]       home_c;

	// Key masked to the configured width
	logic [KeyWidth-1:0] key_in;
	assign key_in = KeyWidth'(req.key);
	assign key32  = 32'(key_q);

	// Home slot: estimated quotient leaves a remainder below twice the slot count
	assign home_c = (diff_q >= RW'(TableSlots)) ?
		AW'(diff_q - RW'(TableSlots)) : AW'(diff_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_done_q <= 1'b0;
			count_q     <= '0;
			longest_q   <= '0;
			psum_q      <= '0;
			ins_q       <= '0;
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
		end else begin
			// Sweep the status memory to empty after reset
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == LastSlot) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (cmd.load) begin
				hash_done_q <= 1'b0;
			end else if (cmd.hash_step && hcnt_q == 2'd3) begin
				hash_done_q <= 1'b1;
			end
			if (cmd.do_insert) begin
				count_q <= count_q + 1'b1;
				if (ins_q != '1) ins_q <= ins_q + 1'b1;
				if (steps_cap > longest_q) longest_q <= steps_cap;
			end
			if (cmd.do_remove) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.probe_inc && psum_q != '1) begin
				psum_q <= psum_q + 1'b1;
			end
		end
	end

	assign steps_cap = (CW > 10 && steps_q > CW'(lphs_pkg::ProbeCap)) ?
		lphs_pkg::ProbeCap : 10'(steps_q);

	// Request capture, home slot hashing and probe pointer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= req.action;
			key_q    <= key_in;
			hcnt_q   <= '0;
			steps_q  <= '0;
		end else if (cmd.hash_step) begin
			// Multiply by reciprocal, back-multiply, subtract, reduce
			prod_q <= key32 * Recip;
			qp_q   <= prod_q[63:32] * SlotsW;
			diff_q <= RW'(key32 - qp_q);
			hcnt_q <= hcnt_q + 1'b1;
			if (hcnt_q == 2'd3) begin
				home_q <= home_c;
				idx_q  <= home_c;
			end
		end else if (cmd.restart) begin
			idx_q   <= home_q;
			steps_q <= '0;
		end else if (cmd.advance) begin
			idx_q   <= (idx_q == LastSlot) ? '0 : idx_q + 1'b1;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.finish) begin
			rsp.status      <= cmd.status;
			rsp.found       <= cmd.found;
			rsp.removed_key <= (cmd.do_remove) ? 32'(key_q) : 32'd0;
			rsp.item_count  <= cmd.do_insert ? count_q + 1'b1 :
				(cmd.do_remove ? count_q - 1'b1 : count_q);
			rsp.max_probes  <= (cmd.do_insert && steps_cap > longest_q) ?
				steps_cap : longest_q;
			rsp.total_probes <= psum_q;
			rsp.insert_count <= (cmd.do_insert && ins_q != '1) ? ins_q + 1'b1 : ins_q;
		end
	end

	// Memory port control
	always_comb begin
		st_we = clr_busy_q || cmd.do_insert || cmd.do_remove;
		key_we = cmd.do_insert;
		ram_addr = clr_busy_q ? clr_idx_q : idx_q;
		st_wd = clr_busy_q ? lphs_pkg::SLOT_EMPTY :
			(cmd.do_insert ? lphs_pkg::SLOT_FULL : lphs_pkg::SLOT_TOMB);
	end

	lphs_ram #(.Width(2), .Depth(TableSlots)) u_status (
		.clk(clk), .we(st_we), .addr(ram_addr), .wdata(st_wd), .rdata(st_rd)
	);
	lphs_ram #(.Width(KeyWidth), .Depth(TableSlots)) u_keys (
		.clk(clk), .we(key_we), .addr(ram_addr), .wdata(key_q), .rdata(key_rd)
	);

	// Status to controller
	always_comb begin
		sts.busy      = clr_busy_q;
		sts.hash_done = hash_done_q;
		sts.action    = lphs_pkg::action_t'(action_q);
		sts.cnt_zero  = (count_q == '0);
		sts.at_limit  = (count_q >= max_items) || (CW'(count_q) >= CW'(TableSlots));
		sts.slot      = lphs_pkg::slot_t'(st_rd);
		sts.key_match = (key_rd == key_q);
		sts.pass_done = (steps_q >= CW'(TableSlots - 1));
	end
endmodule

// ===== design/lphs_ctrl.sv =====
// Controller state machine: sequences hash, search, insert probe and reply.
// Depends on lphs_pkg.
`timescale 1ns / 1ps
module lphs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  lphs_pkg::sts_t sts,
	output lphs_pkg::cmd_t cmd
);
	typedef enum logic [2:0] {
		S_IDLE, S_HASH, S_READ, S_CHECK, S_IREAD, S_ICHECK, S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE) && !sts.busy && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// Per-state commands
	always_comb begin
		cmd = '0;
		cmd.status = lphs_pkg::ST_OK;
		case (state_q)
			S_IDLE: cmd.load = in_valid && in_ready;
			S_HASH: cmd.hash_step = !sts.hash_done;
			S_CHECK: begin
				if (sts.slot == lphs_pkg::SLOT_FULL && sts.key_match) begin
					cmd.finish = 1'b1;
					case (sts.action)
						lphs_pkg::ACT_INSERT: cmd.status = lphs_pkg::ST_DUPLICATE;
						lphs_pkg::ACT_REMOVE: cmd.do_remove = 1'b1;
						default: cmd.found = 1'b1;
					endcase
				end else if (sts.slot == lphs_pkg::SLOT_EMPTY || sts.pass_done) begin
					if (sts.action == lphs_pkg::ACT_INSERT) begin
						cmd.restart = 1'b1;
					end else begin
						cmd.finish = 1'b1;
						cmd.status = lphs_pkg::ST_NOT_FOUND;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_ICHECK: begin
				if (sts.slot != lphs_pkg::SLOT_FULL) begin
					cmd.do_insert = 1'b1;
					cmd.finish = 1'b1;
				end else begin
					cmd.advance = 1'b1;
					cmd.probe_inc = 1'b1;
				end
			end
			// Early-out reply: limit reached, empty set or unused action
			S_DONE: begin
				cmd.finish = 1'b1;
				case (sts.action)
					lphs_pkg::ACT_INSERT: cmd.status = lphs_pkg::ST_OVERFLOW;
					lphs_pkg::ACT_REMOVE: cmd.status = lphs_pkg::ST_UNDERFLOW;
					lphs_pkg::ACT_LOOKUP: cmd.status = lphs_pkg::ST_NOT_FOUND;
					default: cmd.status = lphs_pkg::ST_OK;
				endcase
			end
			default: ;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.load) state_q <= S_HASH;
				S_HASH: if (sts.hash_done) begin
					case (sts.action)
						lphs_pkg::ACT_INSERT: state_q <= sts.at_limit ? S_DONE : S_READ;
						lphs_pkg::ACT_REMOVE, lphs_pkg::ACT_LOOKUP:
							state_q <= sts.cnt_zero ? S_DONE : S_READ;
						default: state_q <= S_DONE;
					endcase
				end
				S_READ: state_q <= S_CHECK;
				S_CHECK: begin
					if (cmd.finish) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
					end else if (cmd.restart) begin
						state_q <= S_IREAD;
					end else begin
						state_q <= S_READ;
					end
				end
				S_IREAD: state_q <= S_ICHECK;
				S_ICHECK: begin
					if (cmd.finish) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= S_IREAD;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
